// ===== sv/sh9_pkg.sv =====
// ----------------------------------------------------------------------------
// sh9_pkg
// Shared constants and types for the order-2 SH irradiance evaluator.
// ----------------------------------------------------------------------------
package sh9_pkg;

    localparam int COEF_WIDTH_DEF = 18;
    localparam int NUM_BASIS_DEF  = 9;
    localparam int NUM_CHANNELS   = 3;

    localparam int NORMAL_W   = 16;
    localparam int CHAN_W     = 2;
    localparam int INDEX_W    = 4;
    localparam int IRR_W      = 15;
    localparam int FRAC_BITS  = 14;
    localparam int ONE_Q14    = 16384;
    localparam int ROUND_HALF = 8192;

    // basis values and second-order terms stay within 18 signed bits
    localparam int BASIS_W = 18;
    // widest second multiplier operand is 3*zz - 1.0
    localparam int OPB_W   = 19;

    localparam int ADDR_W         = $clog2(NUM_CHANNELS * NUM_BASIS_DEF);
    localparam int CMD_FIFO_DEPTH = 4;

    // basis constants, Q2.14
    localparam logic signed [NORMAL_W-1:0] K0 = 16'sd4622;
    localparam logic signed [NORMAL_W-1:0] K1 = 16'sd8005;
    localparam logic signed [NORMAL_W-1:0] K2 = 16'sd17900;
    localparam logic signed [NORMAL_W-1:0] K3 = 16'sd5167;
    localparam logic signed [NORMAL_W-1:0] K4 = 16'sd8950;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_EVAL  = 1'b1;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_EVAL  = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                   kind;
        logic [ADDR_W-1:0]           addr;
        logic signed [NORMAL_W-1:0]  nx;
        logic signed [NORMAL_W-1:0]  ny;
        logic signed [NORMAL_W-1:0]  nz;
    } cmd_hdr_t;

    localparam int HDR_W = $bits(cmd_hdr_t);

    // products of the basis phase, one per step, in issue order
    typedef enum logic [3:0] {
        OP_XX = 4'd0,
        OP_YY = 4'd1,
        OP_ZZ = 4'd2,
        OP_XY = 4'd3,
        OP_YZ = 4'd4,
        OP_XZ = 4'd5,
        OP_B1 = 4'd6,
        OP_B2 = 4'd7,
        OP_B3 = 4'd8,
        OP_B4 = 4'd9,
        OP_B5 = 4'd10,
        OP_B6 = 4'd11,
        OP_B7 = 4'd12,
        OP_B8 = 4'd13
    } basis_op_t;

    localparam int NUM_BASIS_OPS = 14;

endpackage

// ===== sv/sh9_front.sv =====
// ----------------------------------------------------------------------------
// sh9_front
// Input side: takes transactions, checks write addresses and forms commands.
// ----------------------------------------------------------------------------
module sh9_front #(
    parameter int COEF_WIDTH = sh9_pkg::COEF_WIDTH_DEF,
    parameter int NUM_BASIS  = sh9_pkg::NUM_BASIS_DEF
) (
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_mode,
    input  logic [sh9_pkg::CHAN_W-1:0]             s_coef_channel,
    input  logic [sh9_pkg::INDEX_W-1:0]            s_coef_index,
    input  logic signed [COEF_WIDTH-1:0]           s_coef_value,
    input  logic signed [sh9_pkg::NORMAL_W-1:0]    s_normal_x,
    input  logic signed [sh9_pkg::NORMAL_W-1:0]    s_normal_y,
    input  logic signed [sh9_pkg::NORMAL_W-1:0]    s_normal_z,
    input  logic                                   fifo_full,
    output logic                                   push,
    output sh9_pkg::cmd_hdr_t                      push_hdr,
    output logic signed [COEF_WIDTH-1:0]           push_coef
);
    import sh9_pkg::*;

    logic addr_ok;
    logic is_eval;

    always_comb begin
        addr_ok = (int'(s_coef_channel) < NUM_CHANNELS) && (int'(s_coef_index) < NUM_BASIS);
        is_eval = (s_mode == MODE_EVAL);

        s_ready = !fifo_full;
        // writes to a nonexistent entry are consumed and dropped here
        push    = s_valid && s_ready && (is_eval || addr_ok);

        push_hdr.kind = is_eval ? CMD_EVAL : CMD_WRITE;
        push_hdr.addr = ADDR_W'(int'(s_coef_channel) * NUM_BASIS + int'(s_coef_index));
        push_hdr.nx   = s_normal_x;
        push_hdr.ny   = s_normal_y;
        push_hdr.nz   = s_normal_z;
        push_coef     = s_coef_value;
    end

endmodule

// ===== sv/sh9_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// sh9_cmd_fifo
// Small command queue between the input side and the execution side.
// ----------------------------------------------------------------------------
module sh9_cmd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = sh9_pkg::CMD_FIFO_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    always_comb begin
        full     = (count_reg == CNT_W'(DEPTH));
        empty    = (count_reg == '0);
        pop_data = slot_reg[rd_ptr_reg];
        do_push  = push && !full;
        do_pop   = pop && !empty;

        wr_ptr_next = wr_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        rd_ptr_next = rd_ptr_reg;
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/sh9_back.sv =====
// ----------------------------------------------------------------------------
// sh9_back
// Execution side: coefficient store, shared multiplier sequencer, result
// register.
// ----------------------------------------------------------------------------
module sh9_back #(
    parameter int COEF_WIDTH = sh9_pkg::COEF_WIDTH_DEF,
    parameter int NUM_BASIS  = sh9_pkg::NUM_BASIS_DEF,
    parameter int FIFO_W     = sh9_pkg::HDR_W + COEF_WIDTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cmd_empty,
    input  logic [FIFO_W-1:0]           cmd_data,
    output logic                        cmd_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [sh9_pkg::IRR_W-1:0]   m_irr_red,
    output logic [sh9_pkg::IRR_W-1:0]   m_irr_green,
    output logic [sh9_pkg::IRR_W-1:0]   m_irr_blue
);
    import sh9_pkg::*;

    localparam int COEF_DEPTH = NUM_CHANNELS * NUM_BASIS;
    localparam int IDX_W      = $clog2(NUM_BASIS);
    localparam int CH_W       = $clog2(NUM_CHANNELS);
    localparam int MAC_END    = NUM_BASIS_OPS + COEF_DEPTH;
    // room to drain the multiply and writeback stages
    localparam int FIN_STEP   = MAC_END + 2;
    localparam int STEP_W     = $clog2(FIN_STEP + 1);
    localparam int OPA_W      = (COEF_WIDTH > NORMAL_W) ? COEF_WIDTH : NORMAL_W;
    localparam int PROD_W     = OPA_W + OPB_W;
    localparam int RND_W      = PROD_W + 1 - FRAC_BITS;
    localparam int ACC_W      = RND_W + $clog2(NUM_BASIS);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_BUSY = 3'b010,
        ST_HOLD = 3'b100
    } back_state_t;

    function automatic logic [IRR_W-1:0] clamp_q14(input logic signed [ACC_W-1:0] v);
        if (v < 0) begin
            return '0;
        end else if (v > ACC_W'(ONE_Q14)) begin
            return IRR_W'(ONE_Q14);
        end
        return v[IRR_W-1:0];
    endfunction

    // command unpack
    cmd_hdr_t                    cmd_hdr;
    logic signed [COEF_WIDTH-1:0] cmd_coef;

    assign cmd_hdr  = cmd_hdr_t'(cmd_data[FIFO_W-1 -: HDR_W]);
    assign cmd_coef = cmd_data[COEF_WIDTH-1:0];

    // control
    back_state_t          state_reg, state_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic                 st1_valid_reg, st1_valid_next;
    logic                 st1_is_mac_reg;
    logic [IDX_W-1:0]     st1_idx_reg;
    logic [CH_W-1:0]      st1_ch_reg;
    logic                 st2_valid_reg, st2_valid_next;
    logic                 st2_is_mac_reg;
    basis_op_t            st2_op_reg;
    basis_op_t            st1_op_reg;
    logic [CH_W-1:0]      st2_ch_reg;
    logic                 m_valid_reg, m_valid_next;

    logic pop_eval, pop_write, busy, issue_basis, issue_mac, at_fin, out_free, load_out;
    basis_op_t issue_op;

    // datapath
    logic signed [COEF_WIDTH-1:0] coef_mem [COEF_DEPTH];
    logic signed [COEF_WIDTH-1:0] rd_data_reg;
    logic [ADDR_W-1:0]            mac_addr_reg;
    logic [IDX_W-1:0]             mac_idx_reg;
    logic [CH_W-1:0]              mac_ch_reg;

    logic signed [NORMAL_W-1:0]   nx_reg, ny_reg, nz_reg;
    logic signed [BASIS_W-1:0]    xx_reg, yy_reg, zz_reg, xy_reg, yz_reg, xz_reg;
    logic signed [BASIS_W-1:0]    basis_reg [NUM_BASIS];
    logic signed [ACC_W-1:0]      acc_reg [NUM_CHANNELS];

    logic signed [OPA_W-1:0]      op_a, a_reg, mul_a;
    logic signed [OPB_W-1:0]      op_b, b_reg, mul_b;
    logic signed [PROD_W-1:0]     prod_reg;
    logic signed [PROD_W:0]       rnd_sum, rnd_shift;
    logic signed [RND_W-1:0]      rnd_val;

    logic [IRR_W-1:0] irr_red_reg, irr_green_reg, irr_blue_reg;

    always_comb begin
        cmd_pop     = (state_reg == ST_IDLE) && !cmd_empty;
        pop_eval    = cmd_pop && (cmd_hdr.kind == CMD_EVAL);
        pop_write   = cmd_pop && (cmd_hdr.kind == CMD_WRITE);
        busy        = (state_reg == ST_BUSY);
        issue_basis = busy && (step_reg < STEP_W'(NUM_BASIS_OPS));
        issue_mac   = busy && !issue_basis && (step_reg < STEP_W'(MAC_END));
        at_fin      = busy && (step_reg == STEP_W'(FIN_STEP));
        out_free    = !m_valid_reg || m_ready;
        load_out    = (at_fin || (state_reg == ST_HOLD)) && out_free;
        issue_op    = basis_op_t'(step_reg[3:0]);

        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (pop_eval) begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (at_fin) begin
                    state_next = load_out ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        step_next = step_reg;
        if (pop_eval) begin
            step_next = '0;
        end else if (busy && !at_fin) begin
            step_next = step_reg + 1'b1;
        end

        st1_valid_next = issue_basis || issue_mac;
        st2_valid_next = st1_valid_reg;

        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // operand select for the basis phase
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (issue_op)
            OP_XX: begin op_a = OPA_W'(nx_reg); op_b = OPB_W'(nx_reg); end
            OP_YY: begin op_a = OPA_W'(ny_reg); op_b = OPB_W'(ny_reg); end
            OP_ZZ: begin op_a = OPA_W'(nz_reg); op_b = OPB_W'(nz_reg); end
            OP_XY: begin op_a = OPA_W'(nx_reg); op_b = OPB_W'(ny_reg); end
            OP_YZ: begin op_a = OPA_W'(ny_reg); op_b = OPB_W'(nz_reg); end
            OP_XZ: begin op_a = OPA_W'(nx_reg); op_b = OPB_W'(nz_reg); end
            OP_B1: begin op_a = OPA_W'(K1); op_b = OPB_W'(ny_reg); end
            OP_B2: begin op_a = OPA_W'(K1); op_b = OPB_W'(nz_reg); end
            OP_B3: begin op_a = OPA_W'(K1); op_b = OPB_W'(nx_reg); end
            OP_B4: begin op_a = OPA_W'(K2); op_b = OPB_W'(xy_reg); end
            OP_B5: begin op_a = OPA_W'(K2); op_b = OPB_W'(yz_reg); end
            OP_B6: begin
                op_a = OPA_W'(K3);
                op_b = OPB_W'(zz_reg) + OPB_W'(zz_reg) + OPB_W'(zz_reg) - OPB_W'(ONE_Q14);
            end
            OP_B7: begin op_a = OPA_W'(K2); op_b = OPB_W'(xz_reg); end
            OP_B8: begin op_a = OPA_W'(K4); op_b = OPB_W'(xx_reg) - OPB_W'(yy_reg); end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    always_comb begin
        mul_a     = st1_is_mac_reg ? OPA_W'(rd_data_reg) : a_reg;
        mul_b     = st1_is_mac_reg ? OPB_W'(basis_reg[st1_idx_reg]) : b_reg;
        // round half up: floor((p + 0.5) / 1.0)
        rnd_sum   = (PROD_W + 1)'(prod_reg) + (PROD_W + 1)'(ROUND_HALF);
        rnd_shift = rnd_sum >>> FRAC_BITS;
        rnd_val   = rnd_shift[RND_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            st1_valid_reg <= st1_valid_next;
            st2_valid_reg <= st2_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // coefficient store, registered read
    always_ff @(posedge aclk) begin
        if (pop_write) begin
            coef_mem[cmd_hdr.addr] <= cmd_coef;
        end
        rd_data_reg <= coef_mem[mac_addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (pop_eval) begin
            nx_reg       <= cmd_hdr.nx;
            ny_reg       <= cmd_hdr.ny;
            nz_reg       <= cmd_hdr.nz;
            basis_reg[0] <= BASIS_W'(K0);
            mac_addr_reg <= '0;
            mac_idx_reg  <= '0;
            mac_ch_reg   <= '0;
        end else if (issue_mac) begin
            if (mac_addr_reg != ADDR_W'(COEF_DEPTH - 1)) begin
                mac_addr_reg <= mac_addr_reg + 1'b1;
            end
            if (mac_idx_reg == IDX_W'(NUM_BASIS - 1)) begin
                mac_idx_reg <= '0;
                mac_ch_reg  <= mac_ch_reg + 1'b1;
            end else begin
                mac_idx_reg <= mac_idx_reg + 1'b1;
            end
        end

        // issue stage
        st1_is_mac_reg <= issue_mac;
        st1_idx_reg    <= mac_idx_reg;
        st1_ch_reg     <= mac_ch_reg;
        st1_op_reg     <= issue_op;
        a_reg          <= op_a;
        b_reg          <= op_b;

        // multiply stage
        prod_reg       <= mul_a * mul_b;
        st2_is_mac_reg <= st1_is_mac_reg;
        st2_op_reg     <= st1_op_reg;
        st2_ch_reg     <= st1_ch_reg;

        // writeback stage
        if (pop_eval) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                acc_reg[c] <= '0;
            end
        end else if (st2_valid_reg) begin
            if (st2_is_mac_reg) begin
                acc_reg[st2_ch_reg] <= acc_reg[st2_ch_reg] + ACC_W'(rnd_val);
            end else begin
                unique case (st2_op_reg)
                    OP_XX:   xx_reg       <= rnd_val[BASIS_W-1:0];
                    OP_YY:   yy_reg       <= rnd_val[BASIS_W-1:0];
                    OP_ZZ:   zz_reg       <= rnd_val[BASIS_W-1:0];
                    OP_XY:   xy_reg       <= rnd_val[BASIS_W-1:0];
                    OP_YZ:   yz_reg       <= rnd_val[BASIS_W-1:0];
                    OP_XZ:   xz_reg       <= rnd_val[BASIS_W-1:0];
                    OP_B1:   basis_reg[1] <= rnd_val[BASIS_W-1:0];
                    OP_B2:   basis_reg[2] <= rnd_val[BASIS_W-1:0];
                    OP_B3:   basis_reg[3] <= rnd_val[BASIS_W-1:0];
                    OP_B4:   basis_reg[4] <= rnd_val[BASIS_W-1:0];
                    OP_B5:   basis_reg[5] <= rnd_val[BASIS_W-1:0];
                    OP_B6:   basis_reg[6] <= rnd_val[BASIS_W-1:0];
                    OP_B7:   basis_reg[7] <= rnd_val[BASIS_W-1:0];
                    OP_B8:   basis_reg[8] <= rnd_val[BASIS_W-1:0];
                    default: xx_reg       <= xx_reg;
                endcase
            end
        end

        if (load_out) begin
            irr_red_reg   <= clamp_q14(acc_reg[0]);
            irr_green_reg <= clamp_q14(acc_reg[1]);
            irr_blue_reg  <= clamp_q14(acc_reg[2]);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_irr_red   = irr_red_reg;
    assign m_irr_green = irr_green_reg;
    assign m_irr_blue  = irr_blue_reg;

`ifndef SYNTHESIS
    a_pop_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |-> (!st1_valid_reg && !st2_valid_reg))
        else $error("command popped while multiplier pipeline still busy");

    a_hold_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HOLD) |-> (!st1_valid_reg && !st2_valid_reg))
        else $error("pipeline activity while waiting on result slot");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(at_fin || (state_reg == ST_HOLD)))
        else $error("result raised outside the end of an evaluation");

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> (step_reg <= STEP_W'(FIN_STEP)))
        else $error("step counter ran past the end of the sequence");
`endif

endmodule

// ===== sv/sh9_irradiance_eval.sv =====
// ----------------------------------------------------------------------------
// sh9_irradiance_eval
// Order-2 spherical-harmonic irradiance evaluation, RGB, fixed point.
// ----------------------------------------------------------------------------
// Transactions enter a four-entry command queue and are executed in order.
// A coefficient write (mode 0) gives no result; a write to channel 3 or to
// an index above 8 is dropped. An evaluation (mode 1) starts, then issues 14
// products for the basis terms and 27 coefficient-by-basis products, all
// through one shared multiplier at one product per cycle, then drains the
// pipeline and applies the final clamp. The coefficient store is a 27-entry
// memory with a registered read port and has no reset; every coefficient
// must be written before an evaluation reads it. Results sit in an output
// register, so the queue keeps taking transactions while a result waits on
// m_ready.
// ----------------------------------------------------------------------------
module sh9_irradiance_eval #(
    parameter int COEF_WIDTH = sh9_pkg::COEF_WIDTH_DEF,
    parameter int NUM_BASIS  = sh9_pkg::NUM_BASIS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_mode,
    input  logic [sh9_pkg::CHAN_W-1:0]          s_coef_channel,
    input  logic [sh9_pkg::INDEX_W-1:0]         s_coef_index,
    input  logic signed [COEF_WIDTH-1:0]        s_coef_value,
    input  logic signed [sh9_pkg::NORMAL_W-1:0] s_normal_x,
    input  logic signed [sh9_pkg::NORMAL_W-1:0] s_normal_y,
    input  logic signed [sh9_pkg::NORMAL_W-1:0] s_normal_z,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [sh9_pkg::IRR_W-1:0]           m_irr_red,
    output logic [sh9_pkg::IRR_W-1:0]           m_irr_green,
    output logic [sh9_pkg::IRR_W-1:0]           m_irr_blue
);
    import sh9_pkg::*;

    localparam int FIFO_W = HDR_W + COEF_WIDTH;

    logic                         push, fifo_full, fifo_empty, fifo_pop;
    cmd_hdr_t                     push_hdr;
    logic signed [COEF_WIDTH-1:0] push_coef;
    logic [FIFO_W-1:0]            fifo_out;

    sh9_front #(
        .COEF_WIDTH (COEF_WIDTH),
        .NUM_BASIS  (NUM_BASIS)
    ) u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_coef_channel (s_coef_channel),
        .s_coef_index   (s_coef_index),
        .s_coef_value   (s_coef_value),
        .s_normal_x     (s_normal_x),
        .s_normal_y     (s_normal_y),
        .s_normal_z     (s_normal_z),
        .fifo_full      (fifo_full),
        .push           (push),
        .push_hdr       (push_hdr),
        .push_coef      (push_coef)
    );

    sh9_cmd_fifo #(
        .WIDTH (FIFO_W),
        .DEPTH (CMD_FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_hdr, push_coef}),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .pop_data  (fifo_out),
        .empty     (fifo_empty)
    );

    sh9_back #(
        .COEF_WIDTH (COEF_WIDTH),
        .NUM_BASIS  (NUM_BASIS),
        .FIFO_W     (FIFO_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_empty   (fifo_empty),
        .cmd_data    (fifo_out),
        .cmd_pop     (fifo_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_irr_red   (m_irr_red),
        .m_irr_green (m_irr_green),
        .m_irr_blue  (m_irr_blue)
    );

endmodule
